// ===== rtl/core/assert_macros.svh =====
// Assertion helpers. Both sample on the rising edge of clock and are off
// while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FAS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// fas_pkg
// Types and codes shared by the frame animation sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fas_pkg;

   // action codes
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_POS = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  position;
      logic [15:0] new_duration;
      logic [15:0] new_tile;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        animated;
      logic [3:0]  current_position;
      logic [15:0] current_tile;
   } rsp_type;

   // one frame list entry as stored in memory
   typedef struct packed {
      logic [15:0] duration;
      logic [15:0] tile;
   } frame_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_REM_RD,
      S_REM_WR,
      S_FETCH,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/fas_ram.sv =====
// ----------------------------------------------------------------------------
// fas_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fas_seq.sv =====
// ----------------------------------------------------------------------------
// fas_seq
// Sequencer: frame count, shown position, elapsed ticks and the edit sweeps
// that shift the frame memory one entry at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module fas_seq #(
   parameter int MAX_FRAMES = 16,
   localparam int IW = $clog2(MAX_FRAMES),
   localparam int TW = $clog2(MAX_FRAMES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fas_pkg::req_type  req_item,
   output logic              mem_we,
   output logic [IW-1:0]     mem_waddr,
   output fas_pkg::frame_type mem_wdata,
   output logic [IW-1:0]     mem_raddr,
   input  fas_pkg::frame_type mem_rdata,
   output logic              emit,
   output fas_pkg::rsp_type  emit_item
);

   import fas_pkg::*;

   localparam int CW  = (TW > 5) ? TW : 5;
   localparam int TW1 = TW + 1;

   state_type     state_ff, state_in;
   logic [TW-1:0] total_ff, total_in;
   logic [IW-1:0] shown_ff, shown_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic [IW-1:0] cursor_ff, cursor_in;
   req_type       req_ff, req_in;
   logic [1:0]    status_ff, status_in;

   logic          accept;
   logic [IW-1:0] pos_idx, pos_ff_idx, cursor_dec, shown_next;
   logic [CW-1:0] pos_ext, total_ext;
   logic          ins_bad, full, rem_bad, ins_shift, rem_more_idle, rem_more_wr;
   logic [15:0]   tick_inc;
   logic          advance, anim;

   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign pos_idx    = IW'(req_item.position);
   assign pos_ff_idx = IW'(req_ff.position);
   assign pos_ext    = CW'(req_item.position);
   assign total_ext  = CW'(total_ff);
   assign ins_bad    = pos_ext > total_ext;
   assign full       = total_ff == TW'(MAX_FRAMES);
   assign rem_bad    = pos_ext >= total_ext;
   assign ins_shift  = pos_ext != total_ext;
   assign rem_more_idle = (TW1'(pos_idx) + TW1'(1)) < TW1'(total_ff);
   assign rem_more_wr   = (TW1'(cursor_ff) + TW1'(2)) < TW1'(total_ff);
   assign cursor_dec = cursor_ff - IW'(1);
   assign anim       = total_ff != '0;

   // saturating tick and wrap to the first frame
   assign tick_inc   = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign advance    = tick_inc >= mem_rdata.duration;
   assign shown_next = ((TW'(shown_ff) + TW'(1)) == total_ff) ? '0 : shown_ff + IW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_item.action)
                  ACT_TICK:   state_in = anim ? S_TICK : S_FETCH;
                  ACT_INSERT: begin
                     if (ins_bad || full) state_in = S_FETCH;
                     else if (ins_shift) state_in = S_INS_RD;
                     else                state_in = S_INS_PUT;
                  end
                  ACT_REMOVE: begin
                     if (!rem_bad && rem_more_idle) state_in = S_REM_RD;
                     else                           state_in = S_FETCH;
                  end
                  default:    state_in = S_FETCH;
               endcase
            end
         end
         S_TICK:    state_in = advance ? S_FETCH : S_IDLE;
         S_INS_RD:  state_in = S_INS_WR;
         S_INS_WR:  state_in = (cursor_dec == pos_ff_idx) ? S_INS_PUT : S_INS_RD;
         S_INS_PUT: state_in = S_FETCH;
         S_REM_RD:  state_in = S_REM_WR;
         S_REM_WR:  state_in = rem_more_wr ? S_REM_RD : S_FETCH;
         S_FETCH:   state_in = S_EMIT;
         S_EMIT:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // register updates
   always_comb begin
      total_in   = total_ff;
      shown_in   = shown_ff;
      elapsed_in = elapsed_ff;
      cursor_in  = cursor_ff;
      req_in     = req_ff;
      status_in  = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_item;
               status_in = STAT_OK;
               cursor_in = (req_item.action == ACT_INSERT) ? IW'(total_ff) : pos_idx;
               unique case (req_item.action)
                  ACT_INSERT: begin
                     if (ins_bad)   status_in = STAT_BAD_POS;
                     else if (full) status_in = STAT_FULL;
                  end
                  ACT_REMOVE: begin
                     if (rem_bad) begin
                        status_in = STAT_BAD_POS;
                     end else if (!rem_more_idle) begin
                        total_in   = total_ff - TW'(1);
                        shown_in   = '0;
                        elapsed_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TICK: begin
            if (advance) begin
               shown_in   = shown_next;
               elapsed_in = '0;
            end else begin
               elapsed_in = tick_inc;
            end
         end
         S_INS_WR:  cursor_in = cursor_dec;
         S_INS_PUT: begin
            total_in   = total_ff + TW'(1);
            shown_in   = '0;
            elapsed_in = '0;
         end
         S_REM_WR: begin
            cursor_in = cursor_ff + IW'(1);
            if (!rem_more_wr) begin
               total_in   = total_ff - TW'(1);
               shown_in   = '0;
               elapsed_in = '0;
            end
         end
         default: ;
      endcase
   end

   // memory and result outputs
   always_comb begin
      mem_raddr = shown_ff;
      mem_we    = 1'b0;
      mem_waddr = cursor_ff;
      mem_wdata = mem_rdata;
      emit      = 1'b0;
      emit_item.status           = status_ff;
      emit_item.animated         = anim;
      emit_item.current_position = 4'(shown_ff);
      emit_item.current_tile     = anim ? mem_rdata.tile : 16'd0;
      unique case (state_ff)
         S_TICK:   emit = !advance;
         S_INS_RD: mem_raddr = cursor_dec;
         S_INS_WR: mem_we = 1'b1;
         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff_idx;
            mem_wdata.duration = req_ff.new_duration;
            mem_wdata.tile     = req_ff.new_tile;
         end
         S_REM_RD: mem_raddr = cursor_ff + IW'(1);
         S_REM_WR: mem_we = 1'b1;
         S_EMIT:   emit = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         total_ff   <= '0;
         shown_ff   <= '0;
         elapsed_ff <= '0;
      end else begin
         state_ff   <= state_in;
         total_ff   <= total_in;
         shown_ff   <= shown_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      req_ff    <= req_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/frame_animation_sequencer_top.sv =====
// Sequence from accept to result: a tick that stays on its frame emits from the tick
//   state; every other item ends with fetch, then emit, after any shift (insert: read,
//   write per moved frame, then put; remove: read, write per moved frame).
// A new item is taken only while idle; the frame memory moves one entry at a time
//   (read, then write). Reset (synchronous, active high) empties the list
//   and clears position and elapsed ticks, not the memory; results never stall.
`default_nettype none
`include "assert_macros.svh"

module frame_animation_sequencer_top #(
   parameter int MAX_FRAMES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fas_pkg::req_type req_item,
   output logic             rsp_valid,
   output fas_pkg::rsp_type rsp_item
);

   import fas_pkg::*;

   localparam int IW = $clog2(MAX_FRAMES);

   // frame memory port
   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   frame_type     mem_wdata, mem_rdata;

   // result from the sequencer, registered once more before the ports
   logic    emit;
   rsp_type emit_item;

   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;

   // sequencer: owns frame count, shown position and elapsed ticks, and walks
   // the memory for insert/remove shifts
   fas_seq #(
      .MAX_FRAMES(MAX_FRAMES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .emit      (emit),
      .emit_item (emit_item)
   );

   // frame list: duration and tile per entry
   fas_ram #(
      .WIDTH($bits(frame_type)),
      .DEPTH(MAX_FRAMES)
   ) u_frames (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // output register: each item's result shows for exactly one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= emit_item;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // an accepted item always makes the block busy in the following cycle
   `FAS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not set busy")
   // a result only follows work: the block was busy just before it
   `FAS_ASSERT_NOW(a_rsp_after_work, rsp_valid, $past(busy), "result without work")
   // an empty list shows position 0 and tile 0
   `FAS_ASSERT_NOW(a_empty_out, rsp_valid && !rsp_item.animated,
      rsp_item.current_tile == 16'd0 && rsp_item.current_position == 4'd0,
      "empty list shows a frame")
   // a full list cannot be empty
   `FAS_ASSERT_NOW(a_full_animated, rsp_valid && rsp_item.status == STAT_FULL,
      rsp_item.animated, "full status with empty list")

endmodule

`default_nettype wire
